@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the ray pair intersection block
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_IMPLY(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("same-cycle implication failed");
// next-cycle implication
`define ASSERT_NEXT(name, clk, rst, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(name, clk, rst, pre, post)
`define ASSERT_NEXT(name, clk, rst, pre, post)
`endif
`endif

@@ hdl/rri_pkg.sv @@
// ----------------------------------------------------------------------------
// rri_pkg
// Types and constants of the ray pair closest-point intersection block
// ----------------------------------------------------------------------------
package rri_pkg;

  // arithmetic widths
  localparam int CROSS_W = 65;   // signed cross product component
  localparam int MAG_W   = 64;   // magnitude of a cross product component
  localparam int PROD_W  = 128;  // product of two magnitudes
  localparam int DOT_W   = 130;  // magnitude of a three-term dot product
  localparam int QUO_W   = 31;   // quotient bits below the saturation bit
  localparam int DIV_W   = DOT_W + QUO_W;
  localparam int QUEUE_DEPTH = 2;

  // outcome codes
  localparam logic [1:0] OUTCOME_HIT        = 2'd0;
  localparam logic [1:0] OUTCOME_APART      = 2'd1;
  localparam logic [1:0] OUTCOME_SKEW       = 2'd2;
  localparam logic [1:0] OUTCOME_COINCIDENT = 2'd3;

  // register index, taken from paddr[2]
  localparam logic REG_THRESHOLD = 1'b0;

  localparam logic signed [31:0] T_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] T_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic signed [31:0] ray0_origin_x;
    logic signed [31:0] ray0_origin_y;
    logic signed [31:0] ray0_origin_z;
    logic signed [31:0] ray0_dir_x;
    logic signed [31:0] ray0_dir_y;
    logic signed [31:0] ray0_dir_z;
    logic signed [31:0] ray1_origin_x;
    logic signed [31:0] ray1_origin_y;
    logic signed [31:0] ray1_origin_z;
    logic signed [31:0] ray1_dir_x;
    logic signed [31:0] ray1_dir_y;
    logic signed [31:0] ray1_dir_z;
  } rri_in_t;

  typedef struct packed {
    logic        [1:0]  outcome;
    logic signed [31:0] param_first;
    logic signed [31:0] param_second;
  } rri_out_t;

  // what travels with an item through the back end
  typedef struct packed {
    logic [2:0][32:0] w;       // p1 - p0
    logic [2:0][31:0] d0;
    logic [2:0][31:0] d1;
    logic             parallel;
    logic             near;    // origins within threshold
  } rri_base_t;

  typedef struct packed {
    rri_base_t                base;
    logic [2:0][CROSS_W-1:0] c;
    logic [2:0][CROSS_W-1:0] wx1;
    logic [2:0][CROSS_W-1:0] wx0;
  } rri_work_t;

endpackage

@@ hdl/rri_fifo.sv @@
// ----------------------------------------------------------------------------
// rri_fifo
// Small register queue with first-word fall-through read
// ----------------------------------------------------------------------------
module rri_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

endmodule

@@ hdl/rri_front.sv @@
// ----------------------------------------------------------------------------
// rri_front
// Accepts ray pairs, forms cross products and classifies parallel pairs
// ----------------------------------------------------------------------------
module rri_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                take,
  input  rri_pkg::rri_in_t    rays,
  input  logic [30:0]         thr,
  input  logic [61:0]         thr_sq,
  input  logic                stall,
  output rri_pkg::rri_work_t  work,
  output logic                work_push
);

  logic adv;

  logic               s1_v;
  logic signed [31:0] s1_d0 [3];
  logic signed [31:0] s1_d1 [3];
  logic signed [32:0] s1_w  [3];

  logic               s2_v;
  logic signed [31:0] s2_d0 [3];
  logic signed [31:0] s2_d1 [3];
  logic signed [32:0] s2_w  [3];
  logic signed [63:0] s2_cp [3];
  logic signed [63:0] s2_cn [3];
  logic signed [64:0] s2_ap1 [3];
  logic signed [64:0] s2_an1 [3];
  logic signed [64:0] s2_ap0 [3];
  logic signed [64:0] s2_an0 [3];
  logic               s2_wgt [3];
  logic [61:0]        s2_wsq [3];

  logic [32:0]        wm [3];
  logic [65:0]        dx1 [3];
  logic [65:0]        dx0 [3];
  logic [63:0]        wsum;

  assign adv       = !stall;
  assign work_push = s2_v && adv;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else if (adv) begin
      s1_v <= take;
      s2_v <= s1_v;
    end
  end

  // stage 1: capture beat, origin difference
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d0[0] <= rays.ray0_dir_x;
      s1_d0[1] <= rays.ray0_dir_y;
      s1_d0[2] <= rays.ray0_dir_z;
      s1_d1[0] <= rays.ray1_dir_x;
      s1_d1[1] <= rays.ray1_dir_y;
      s1_d1[2] <= rays.ray1_dir_z;
      s1_w[0]  <= $signed({rays.ray1_origin_x[31], rays.ray1_origin_x})
                - $signed({rays.ray0_origin_x[31], rays.ray0_origin_x});
      s1_w[1]  <= $signed({rays.ray1_origin_y[31], rays.ray1_origin_y})
                - $signed({rays.ray0_origin_y[31], rays.ray0_origin_y});
      s1_w[2]  <= $signed({rays.ray1_origin_z[31], rays.ray1_origin_z})
                - $signed({rays.ray0_origin_z[31], rays.ray0_origin_z});
    end
  end

  // origin distance magnitudes
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      wm[i] = s1_w[i][32] ? (~s1_w[i] + 1'b1) : s1_w[i];
    end
  end

  // stage 2: cross product terms and origin distance squares
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s2_d0[i]  <= s1_d0[i];
        s2_d1[i]  <= s1_d1[i];
        s2_w[i]   <= s1_w[i];
        s2_wgt[i] <= wm[i] > {2'b00, thr};
        s2_wsq[i] <= wm[i][30:0] * wm[i][30:0];
      end
      s2_cp[0]  <= s1_d0[1] * s1_d1[2];
      s2_cn[0]  <= s1_d0[2] * s1_d1[1];
      s2_cp[1]  <= s1_d0[2] * s1_d1[0];
      s2_cn[1]  <= s1_d0[0] * s1_d1[2];
      s2_cp[2]  <= s1_d0[0] * s1_d1[1];
      s2_cn[2]  <= s1_d0[1] * s1_d1[0];
      s2_ap1[0] <= s1_w[1] * s1_d1[2];
      s2_an1[0] <= s1_w[2] * s1_d1[1];
      s2_ap1[1] <= s1_w[2] * s1_d1[0];
      s2_an1[1] <= s1_w[0] * s1_d1[2];
      s2_ap1[2] <= s1_w[0] * s1_d1[1];
      s2_an1[2] <= s1_w[1] * s1_d1[0];
      s2_ap0[0] <= s1_w[1] * s1_d0[2];
      s2_an0[0] <= s1_w[2] * s1_d0[1];
      s2_ap0[1] <= s1_w[2] * s1_d0[0];
      s2_an0[1] <= s1_w[0] * s1_d0[2];
      s2_ap0[2] <= s1_w[0] * s1_d0[1];
      s2_an0[2] <= s1_w[1] * s1_d0[0];
    end
  end

  // cross differences and classification into the queue
  assign wsum = {2'b00, s2_wsq[0]} + {2'b00, s2_wsq[1]} + {2'b00, s2_wsq[2]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dx1[i] = {s2_ap1[i][64], s2_ap1[i]} - {s2_an1[i][64], s2_an1[i]};
      dx0[i] = {s2_ap0[i][64], s2_ap0[i]} - {s2_an0[i][64], s2_an0[i]};
      work.base.w[i]  = s2_w[i];
      work.base.d0[i] = s2_d0[i];
      work.base.d1[i] = s2_d1[i];
      work.c[i]       = {s2_cp[i][63], s2_cp[i]} - {s2_cn[i][63], s2_cn[i]};
      work.wx1[i]     = dx1[i][64:0];
      work.wx0[i]     = dx0[i][64:0];
    end
    work.base.parallel = (s2_cp[0] == s2_cn[0]) && (s2_cp[1] == s2_cn[1])
                      && (s2_cp[2] == s2_cn[2]);
    work.base.near     = !(s2_wgt[0] || s2_wgt[1] || s2_wgt[2])
                      && (wsum <= {2'b00, thr_sq});
  end

endmodule

@@ hdl/rri_back.sv @@
// ----------------------------------------------------------------------------
// rri_back
// Dot products, pipelined parameter division and closest-point distance test
// ----------------------------------------------------------------------------
module rri_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [30:0]        thr,
  input  logic [61:0]        thr_sq,
  input  rri_pkg::rri_work_t work,
  input  logic               work_valid,
  output logic               work_take,
  output rri_pkg::rri_out_t  res,
  output logic               res_push,
  input  logic               out_full
);

  localparam int MAG_W  = rri_pkg::MAG_W;
  localparam int PROD_W = rri_pkg::PROD_W;
  localparam int DOT_W  = rri_pkg::DOT_W;
  localparam int QUO_W  = rri_pkg::QUO_W;
  localparam int DIV_W  = rri_pkg::DIV_W;
  localparam int NSTEP  = QUO_W + 1;

  function automatic logic [MAG_W-1:0] abs_cross(input logic [rri_pkg::CROSS_W-1:0] x);
    logic [rri_pkg::CROSS_W-1:0] n;
    n = x[rri_pkg::CROSS_W-1] ? (~x + 1'b1) : x;
    return n[MAG_W-1:0];
  endfunction

  function automatic logic [DOT_W:0] signed_term(input logic [PROD_W-1:0] p, input logic neg);
    logic [DOT_W:0] e;
    e = {3'b000, p};
    return neg ? (~e + 1'b1) : e;
  endfunction

  logic adv;

  // stage b1: magnitudes and signs
  logic               b1_v;
  rri_pkg::rri_base_t b1_base;
  logic [MAG_W-1:0]   b1_cm [3];
  logic [MAG_W-1:0]   b1_m1 [3];
  logic [MAG_W-1:0]   b1_m0 [3];
  logic               b1_cs [3];
  logic               b1_s1 [3];
  logic               b1_s0 [3];

  // stage b2: partial products
  logic               b2_v;
  rri_pkg::rri_base_t b2_base;
  logic [63:0]        b2_pp  [9][4];
  logic               b2_neg [9];
  logic [MAG_W-1:0]   op_a   [9];
  logic [MAG_W-1:0]   op_b   [9];
  logic               op_neg [9];

  // stage b3: full products
  logic               b3_v;
  rri_pkg::rri_base_t b3_base;
  logic [PROD_W-1:0]  b3_prod [9];
  logic               b3_neg  [9];

  // stage b4: dot products
  logic               b4_v;
  rri_pkg::rri_base_t b4_base;
  logic [DOT_W-1:0]   b4_den;
  logic [DOT_W:0]     b4_n0;
  logic [DOT_W:0]     b4_n1;
  logic [DOT_W:0]     n0_abs;
  logic [DOT_W:0]     n1_abs;

  // divider stages, entry 0 holds the shifted numerators
  logic               dv_v    [NSTEP+1];
  rri_pkg::rri_base_t dv_base [NSTEP+1];
  logic [DIV_W-1:0]   dv_rem0 [NSTEP+1];
  logic [DIV_W-1:0]   dv_rem1 [NSTEP+1];
  logic [DOT_W-1:0]   dv_den  [NSTEP+1];
  logic [QUO_W-1:0]   dv_q0   [NSTEP+1];
  logic [QUO_W-1:0]   dv_q1   [NSTEP+1];
  logic               dv_sat0 [NSTEP+1];
  logic               dv_sat1 [NSTEP+1];
  logic               dv_neg0 [NSTEP+1];
  logic               dv_neg1 [NSTEP+1];

  // parameter, products, distance stages
  logic               bt_v;
  rri_pkg::rri_base_t bt_base;
  logic signed [31:0] bt_t0;
  logic signed [31:0] bt_t1;
  logic               bm_v;
  rri_pkg::rri_base_t bm_base;
  logic signed [31:0] bm_t0;
  logic signed [31:0] bm_t1;
  logic signed [63:0] bm_pr0 [3];
  logic signed [63:0] bm_pr1 [3];
  logic               be_v;
  logic               be_parallel;
  logic               be_near;
  logic signed [31:0] be_t0;
  logic signed [31:0] be_t1;
  logic [63:0]        be_e [3];
  logic               bw_v;
  logic               bw_parallel;
  logic               bw_near;
  logic signed [31:0] bw_t0;
  logic signed [31:0] bw_t1;
  logic               bw_gt [3];
  logic [61:0]        bw_sq [3];

  logic [63:0]        pm0 [3];
  logic [63:0]        pm1 [3];
  logic [63:0]        sc0 [3];
  logic [63:0]        sc1 [3];
  logic [63:0]        em  [3];
  logic [63:0]        esum;
  logic               hit;

  assign adv       = !out_full;
  assign work_take = adv && work_valid;

  // valid chain outside the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      b1_v <= 1'b0;
      b2_v <= 1'b0;
      b3_v <= 1'b0;
      b4_v <= 1'b0;
      bt_v <= 1'b0;
      bm_v <= 1'b0;
      be_v <= 1'b0;
      bw_v <= 1'b0;
    end else if (adv) begin
      b1_v <= work_take;
      b2_v <= b1_v;
      b3_v <= b2_v;
      b4_v <= b3_v;
      bt_v <= dv_v[NSTEP];
      bm_v <= bt_v;
      be_v <= bm_v;
      bw_v <= be_v;
    end
  end

  // b1: split signs from magnitudes
  always_ff @(posedge clk) begin
    if (adv) begin
      b1_base <= work.base;
      for (int i = 0; i < 3; i++) begin
        b1_cm[i] <= abs_cross(work.c[i]);
        b1_m1[i] <= abs_cross(work.wx1[i]);
        b1_m0[i] <= abs_cross(work.wx0[i]);
        b1_cs[i] <= work.c[i][rri_pkg::CROSS_W-1];
        b1_s1[i] <= work.wx1[i][rri_pkg::CROSS_W-1];
        b1_s0[i] <= work.wx0[i][rri_pkg::CROSS_W-1];
      end
    end
  end

  // operand selection: c.c, (w x d1).c, (w x d0).c
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      op_a[i]       = b1_cm[i];
      op_b[i]       = b1_cm[i];
      op_neg[i]     = 1'b0;
      op_a[3 + i]   = b1_m1[i];
      op_b[3 + i]   = b1_cm[i];
      op_neg[3 + i] = b1_s1[i] ^ b1_cs[i];
      op_a[6 + i]   = b1_m0[i];
      op_b[6 + i]   = b1_cm[i];
      op_neg[6 + i] = b1_s0[i] ^ b1_cs[i];
    end
  end

  // b2: 32 by 32 partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      b2_base <= b1_base;
      for (int k = 0; k < 9; k++) begin
        b2_neg[k]   <= op_neg[k];
        b2_pp[k][0] <= op_a[k][31:0]  * op_b[k][31:0];
        b2_pp[k][1] <= op_a[k][31:0]  * op_b[k][63:32];
        b2_pp[k][2] <= op_a[k][63:32] * op_b[k][31:0];
        b2_pp[k][3] <= op_a[k][63:32] * op_b[k][63:32];
      end
    end
  end

  // b3: combine partial products
  always_ff @(posedge clk) begin
    if (adv) begin
      b3_base <= b2_base;
      for (int k = 0; k < 9; k++) begin
        b3_neg[k]  <= b2_neg[k];
        b3_prod[k] <= {64'd0, b2_pp[k][0]} + {32'd0, b2_pp[k][1], 32'd0}
                    + {32'd0, b2_pp[k][2], 32'd0} + {b2_pp[k][3], 64'd0};
      end
    end
  end

  // b4: signed dot product sums
  always_ff @(posedge clk) begin
    if (adv) begin
      b4_base <= b3_base;
      b4_den  <= {2'b00, b3_prod[0]} + {2'b00, b3_prod[1]} + {2'b00, b3_prod[2]};
      b4_n0   <= signed_term(b3_prod[3], b3_neg[3]) + signed_term(b3_prod[4], b3_neg[4])
               + signed_term(b3_prod[5], b3_neg[5]);
      b4_n1   <= signed_term(b3_prod[6], b3_neg[6]) + signed_term(b3_prod[7], b3_neg[7])
               + signed_term(b3_prod[8], b3_neg[8]);
    end
  end

  // numerator magnitudes, scaled by the fraction bits
  assign n0_abs = b4_n0[DOT_W] ? (~b4_n0 + 1'b1) : b4_n0;
  assign n1_abs = b4_n1[DOT_W] ? (~b4_n1 + 1'b1) : b4_n1;

  always_ff @(posedge clk) begin
    if (rst) begin
      dv_v[0] <= 1'b0;
    end else if (adv) begin
      dv_v[0] <= b4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv_base[0] <= b4_base;
      dv_den[0]  <= b4_den;
      dv_neg0[0] <= b4_n0[DOT_W];
      dv_neg1[0] <= b4_n1[DOT_W];
      dv_rem0[0] <= {{QUO_W{1'b0}}, n0_abs[DOT_W-1:0]} << FRAC_BITS;
      dv_rem1[0] <= {{QUO_W{1'b0}}, n1_abs[DOT_W-1:0]} << FRAC_BITS;
      dv_q0[0]   <= '0;
      dv_q1[0]   <= '0;
      dv_sat0[0] <= 1'b0;
      dv_sat1[0] <= 1'b0;
    end
  end

  // restoring divider, one quotient bit per stage; first stage is the overflow test
  for (genvar k = 0; k < NSTEP; k++) begin : g_div
    localparam int BIT = QUO_W - k;
    logic [DIV_W-1:0] sh;
    logic             ge0;
    logic             ge1;

    assign sh  = {{QUO_W{1'b0}}, dv_den[k]} << BIT;
    assign ge0 = dv_rem0[k] >= sh;
    assign ge1 = dv_rem1[k] >= sh;

    always_ff @(posedge clk) begin
      if (rst) begin
        dv_v[k+1] <= 1'b0;
      end else if (adv) begin
        dv_v[k+1] <= dv_v[k];
      end
    end

    if (k == 0) begin : g_sat
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem0[k+1] <= dv_rem0[k];
          dv_rem1[k+1] <= dv_rem1[k];
          dv_q0[k+1]   <= dv_q0[k];
          dv_q1[k+1]   <= dv_q1[k];
          dv_sat0[k+1] <= ge0;
          dv_sat1[k+1] <= ge1;
        end
      end
    end else begin : g_step
      always_ff @(posedge clk) begin
        if (adv) begin
          dv_rem0[k+1] <= ge0 ? dv_rem0[k] - sh : dv_rem0[k];
          dv_rem1[k+1] <= ge1 ? dv_rem1[k] - sh : dv_rem1[k];
          dv_q0[k+1]   <= dv_q0[k] | (QUO_W'(ge0) << BIT);
          dv_q1[k+1]   <= dv_q1[k] | (QUO_W'(ge1) << BIT);
          dv_sat0[k+1] <= dv_sat0[k];
          dv_sat1[k+1] <= dv_sat1[k];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dv_base[k+1] <= dv_base[k];
        dv_den[k+1]  <= dv_den[k];
        dv_neg0[k+1] <= dv_neg0[k];
        dv_neg1[k+1] <= dv_neg1[k];
      end
    end
  end

  // bt: signed, saturated parameters; parallel pairs carry zero
  always_ff @(posedge clk) begin
    if (adv) begin
      bt_base <= dv_base[NSTEP];
      if (dv_base[NSTEP].parallel) begin
        bt_t0 <= '0;
        bt_t1 <= '0;
      end else begin
        bt_t0 <= dv_sat0[NSTEP] ? (dv_neg0[NSTEP] ? rri_pkg::T_MIN : rri_pkg::T_MAX)
               : dv_neg0[NSTEP] ? -$signed({1'b0, dv_q0[NSTEP]})
               : $signed({1'b0, dv_q0[NSTEP]});
        bt_t1 <= dv_sat1[NSTEP] ? (dv_neg1[NSTEP] ? rri_pkg::T_MIN : rri_pkg::T_MAX)
               : dv_neg1[NSTEP] ? -$signed({1'b0, dv_q1[NSTEP]})
               : $signed({1'b0, dv_q1[NSTEP]});
      end
    end
  end

  // bm: direction times parameter
  always_ff @(posedge clk) begin
    if (adv) begin
      bm_base <= bt_base;
      bm_t0   <= bt_t0;
      bm_t1   <= bt_t1;
      for (int i = 0; i < 3; i++) begin
        bm_pr0[i] <= $signed(bt_base.d0[i]) * bt_t0;
        bm_pr1[i] <= $signed(bt_base.d1[i]) * bt_t1;
      end
    end
  end

  // scale back toward zero
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pm0[i] = bm_pr0[i][63] ? (~bm_pr0[i] + 1'b1) : bm_pr0[i];
      pm1[i] = bm_pr1[i][63] ? (~bm_pr1[i] + 1'b1) : bm_pr1[i];
      sc0[i] = bm_pr0[i][63] ? ~(pm0[i] >> FRAC_BITS) + 1'b1 : (pm0[i] >> FRAC_BITS);
      sc1[i] = bm_pr1[i][63] ? ~(pm1[i] >> FRAC_BITS) + 1'b1 : (pm1[i] >> FRAC_BITS);
    end
  end

  // be: gap between closest points
  always_ff @(posedge clk) begin
    if (adv) begin
      be_parallel <= bm_base.parallel;
      be_near     <= bm_base.near;
      be_t0       <= bm_t0;
      be_t1       <= bm_t1;
      for (int i = 0; i < 3; i++) begin
        be_e[i] <= {{31{bm_base.w[i][32]}}, bm_base.w[i]} + sc1[i] - sc0[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      em[i] = be_e[i][63] ? (~be_e[i] + 1'b1) : be_e[i];
    end
  end

  // bw: per-axis limit and squares
  always_ff @(posedge clk) begin
    if (adv) begin
      bw_parallel <= be_parallel;
      bw_near     <= be_near;
      bw_t0       <= be_t0;
      bw_t1       <= be_t1;
      for (int i = 0; i < 3; i++) begin
        bw_gt[i] <= em[i] > {33'd0, thr};
        bw_sq[i] <= em[i][30:0] * em[i][30:0];
      end
    end
  end

  // outcome into the result queue
  assign esum = {2'b00, bw_sq[0]} + {2'b00, bw_sq[1]} + {2'b00, bw_sq[2]};
  assign hit  = !(bw_gt[0] || bw_gt[1] || bw_gt[2]) && (esum <= {2'b00, thr_sq});

  always_comb begin
    if (bw_parallel) begin
      res.outcome = bw_near ? rri_pkg::OUTCOME_COINCIDENT : rri_pkg::OUTCOME_APART;
    end else begin
      res.outcome = hit ? rri_pkg::OUTCOME_HIT : rri_pkg::OUTCOME_SKEW;
    end
    res.param_first  = bw_t0;
    res.param_second = bw_t1;
  end

  assign res_push = bw_v && adv;

endmodule

@@ hdl/ray_ray_intersection_test.sv @@
// ----------------------------------------------------------------------------
// ray_ray_intersection_test
// Closest-point test of two rays in signed fixed point, one pair per beat
// ----------------------------------------------------------------------------
// Ray pairs enter on push/full/rays; a beat is taken when push is high and
// full is low. Results leave on empty/pop/result; the oldest result is shown
// while empty is low and leaves when pop is high.
// Most of the pipeline is the 32 stages of the pipelined restoring divider
// that forms the two ray parameters. One pair is taken every cycle while
// results drain.
// The front end (capture and cross products) and the back end (dot products,
// divider, distance test) sit either side of a two-entry queue; each stalls
// on its own. When pop stays low the result queue fills, the back end holds,
// then the middle queue fills and full rises; no beat is lost.
// The distance threshold is written over the APB port at byte address 0.
// Synchronous reset empties both queues and all pipeline stages and sets the
// threshold to 1/32 in the fixed-point format.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ray_ray_intersection_test #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  rri_pkg::rri_in_t   rays,
  output logic               empty,
  input  logic               pop,
  output rri_pkg::rri_out_t  result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [30:0] THR_RESET = 31'(1) << (FRAC_BITS - 5);
  localparam int WORK_W = $bits(rri_pkg::rri_work_t);
  localparam int RES_W  = $bits(rri_pkg::rri_out_t);

  logic [30:0]        threshold;
  logic [61:0]        thr_sq;
  logic               take;
  rri_pkg::rri_work_t mid_in;
  rri_pkg::rri_work_t mid_out;
  logic [WORK_W-1:0]  mid_rdata;
  logic               mid_push;
  logic               mid_pop;
  logic               mid_full;
  logic               mid_empty;
  rri_pkg::rri_out_t  res;
  logic [RES_W-1:0]   out_rdata;
  logic               res_push;
  logic               out_full;
  logic               cfg_write;
  logic               res_parallel;
  logic               res_zero;

  // configuration port
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == rri_pkg::REG_THRESHOLD) ? {1'b0, threshold} : '0;
  assign cfg_write = psel && penable && pwrite && pready
                  && paddr[2] == rri_pkg::REG_THRESHOLD;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_write) begin
      threshold <= pwdata[30:0];
    end
  end

  // squared threshold for the distance compares
  always_ff @(posedge clk) begin
    thr_sq <= threshold * threshold;
  end

  assign take = push && !full;
  assign full = mid_full;

  // front end
  rri_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .rays      (rays),
    .thr       (threshold),
    .thr_sq    (thr_sq),
    .stall     (mid_full),
    .work      (mid_in),
    .work_push (mid_push)
  );

  // queue between front and back
  rri_fifo #(
    .WIDTH (WORK_W),
    .DEPTH (rri_pkg::QUEUE_DEPTH)
  ) u_mid_q (
    .clk   (clk),
    .rst   (rst),
    .push  (mid_push),
    .wdata (mid_in),
    .pop   (mid_pop),
    .rdata (mid_rdata),
    .full  (mid_full),
    .empty (mid_empty)
  );

  assign mid_out = rri_pkg::rri_work_t'(mid_rdata);

  // back end
  rri_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .thr        (threshold),
    .thr_sq     (thr_sq),
    .work       (mid_out),
    .work_valid (!mid_empty),
    .work_take  (mid_pop),
    .res        (res),
    .res_push   (res_push),
    .out_full   (out_full)
  );

  // result queue
  rri_fifo #(
    .WIDTH (RES_W),
    .DEPTH (rri_pkg::QUEUE_DEPTH)
  ) u_out_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res),
    .pop   (pop),
    .rdata (out_rdata),
    .full  (out_full),
    .empty (empty)
  );

  assign result = rri_pkg::rri_out_t'(out_rdata);

  // checks
  assign res_parallel = !empty && (result.outcome == rri_pkg::OUTCOME_APART
                                || result.outcome == rri_pkg::OUTCOME_COINCIDENT);
  assign res_zero     = (result.param_first == '0) && (result.param_second == '0);

  `ASSERT_IMPLY(a_mid_no_overflow, clk, rst, mid_push, !mid_full)
  `ASSERT_IMPLY(a_out_no_overflow, clk, rst, res_push, !out_full)
  `ASSERT_IMPLY(a_parallel_zero, clk, rst, res_parallel, res_zero)
  `ASSERT_NEXT(a_cfg_write, clk, rst, cfg_write, threshold == $past(pwdata[30:0]))

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Checks the ray pair closest-point block at several distance thresholds:
// directed rows and random pairs are pushed, mostly with random gaps; every
// result is checked per field against a typed or exact wide-arithmetic value.
// ----------------------------------------------------------------------------
module tb;

  localparam int SETTLE = 60;  // beyond the pipeline latency

  typedef struct {
    rri_pkg::rri_in_t  rays;
    bit                typed;
    rri_pkg::rri_out_t want;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       push;
  logic       full;
  rri_pkg::rri_in_t  rays;
  logic       empty;
  logic       pop;
  rri_pkg::rri_out_t result;
  logic       psel;
  logic       penable;
  logic       pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic       pready;

  rri_pkg::rri_out_t pending_q[$];
  stim_row_t  directed[$];
  bit [30:0]  threshold;
  bit         gaps_on;
  int         errors;

  ray_ray_intersection_test dut (
    .clk(clk), .rst(rst), .push(push), .full(full), .rays(rays),
    .empty(empty), .pop(pop), .result(result),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("ray_ray_intersection_test test failed");
    $finish;
  end

  // squared-distance test of a separation vector
  function automatic bit is_close(logic signed [255:0] e[3], bit [30:0] thr);
    logic signed [255:0] m;
    logic signed [255:0] sum;
    logic signed [255:0] lim;
    sum = 0;
    lim = thr;
    for (int i = 0; i < 3; i++) begin
      m = (e[i] < 0) ? -e[i] : e[i];
      if (m > lim) return 1'b0;
      sum = sum + m * m;
    end
    return sum <= lim * lim;
  endfunction

  // num * 2^16 / den, truncated toward zero, saturated
  function automatic logic signed [31:0] ray_param(logic signed [255:0] num,
                                                    logic signed [255:0] den);
    logic signed [255:0] q;
    q = (((num < 0) ? -num : num) <<< 16) / den;
    if (q >= (256'sd1 <<< 31)) return (num < 0) ? rri_pkg::T_MIN : rri_pkg::T_MAX;
    return (num < 0) ? -q[31:0] : q[31:0];
  endfunction

  // d * t / 2^16, truncated toward zero
  function automatic logic signed [255:0] scale_dir(logic signed [255:0] d,
                                                     logic signed [255:0] t);
    logic signed [255:0] pr;
    pr = d * t;
    return (pr < 0) ? -((-pr) >>> 16) : (pr >>> 16);
  endfunction

  function automatic rri_pkg::rri_out_t closest_approach(rri_pkg::rri_in_t r,
                                                         bit [30:0] thr);
    logic signed [255:0] p0[3], d0[3], p1[3], d1[3], w[3];
    logic signed [255:0] c[3], wx1[3], wx0[3], e[3];
    logic signed [255:0] den, n0, n1;
    rri_pkg::rri_out_t o;
    p0[0] = r.ray0_origin_x; p0[1] = r.ray0_origin_y; p0[2] = r.ray0_origin_z;
    d0[0] = r.ray0_dir_x;    d0[1] = r.ray0_dir_y;    d0[2] = r.ray0_dir_z;
    p1[0] = r.ray1_origin_x; p1[1] = r.ray1_origin_y; p1[2] = r.ray1_origin_z;
    d1[0] = r.ray1_dir_x;    d1[1] = r.ray1_dir_y;    d1[2] = r.ray1_dir_z;
    for (int i = 0; i < 3; i++) w[i] = p1[i] - p0[i];
    for (int i = 0; i < 3; i++) begin
      c[i]   = d0[(i+1)%3] * d1[(i+2)%3] - d0[(i+2)%3] * d1[(i+1)%3];
      wx1[i] = w[(i+1)%3] * d1[(i+2)%3] - w[(i+2)%3] * d1[(i+1)%3];
      wx0[i] = w[(i+1)%3] * d0[(i+2)%3] - w[(i+2)%3] * d0[(i+1)%3];
    end
    o.param_first  = '0;
    o.param_second = '0;
    if (c[0] == 0 && c[1] == 0 && c[2] == 0) begin
      o.outcome = is_close(w, thr) ? rri_pkg::OUTCOME_COINCIDENT : rri_pkg::OUTCOME_APART;
    end else begin
      den = c[0]*c[0] + c[1]*c[1] + c[2]*c[2];
      n0  = wx1[0]*c[0] + wx1[1]*c[1] + wx1[2]*c[2];
      n1  = wx0[0]*c[0] + wx0[1]*c[1] + wx0[2]*c[2];
      o.param_first  = ray_param(n0, den);
      o.param_second = ray_param(n1, den);
      for (int i = 0; i < 3; i++)
        e[i] = (p1[i] + scale_dir(d1[i], o.param_second))
             - (p0[i] + scale_dir(d0[i], o.param_first));
      o.outcome = is_close(e, thr) ? rri_pkg::OUTCOME_HIT : rri_pkg::OUTCOME_SKEW;
    end
    return o;
  endfunction

  function automatic int near_val(int range);
    return int'($urandom_range(0, 2 * range)) - range;
  endfunction

  // random pair: mostly meeting or parallel rays, some noise
  function automatic rri_pkg::rri_in_t random_pair();
    rri_pkg::rri_in_t r;
    int kind;
    int a, b, k;
    kind = $urandom_range(0, 9);
    r.ray0_origin_x = near_val(1 << 20); r.ray0_origin_y = near_val(1 << 20);
    r.ray0_origin_z = near_val(1 << 20);
    r.ray0_dir_x = near_val(4) <<< 16; r.ray0_dir_y = near_val(4) <<< 16;
    r.ray0_dir_z = near_val(4) <<< 16;
    r.ray1_dir_x = near_val(4) <<< 16; r.ray1_dir_y = near_val(4) <<< 16;
    r.ray1_dir_z = near_val(4) <<< 16;
    a = near_val(6);
    b = near_val(6);
    if (kind < 2) begin
      r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    end else if (kind < 4) begin
      r.ray1_origin_x = near_val(1 << 20); r.ray1_origin_y = near_val(1 << 20);
      r.ray1_origin_z = near_val(1 << 20);
      r.ray0_dir_x = near_val(1 << 18); r.ray1_dir_y = near_val(1 << 18);
    end else if (kind < 8) begin
      // rays that meet at integer parameters, sometimes nudged apart
      r.ray1_origin_x = r.ray0_origin_x + a * r.ray0_dir_x - b * r.ray1_dir_x;
      r.ray1_origin_y = r.ray0_origin_y + a * r.ray0_dir_y - b * r.ray1_dir_y;
      r.ray1_origin_z = r.ray0_origin_z + a * r.ray0_dir_z - b * r.ray1_dir_z
                      + (($urandom_range(0, 2) == 0) ? near_val(1 << 12) : 0);
    end else begin
      // parallel directions, origins near or along the line
      k = near_val(3);
      r.ray1_dir_x = k * r.ray0_dir_x; r.ray1_dir_y = k * r.ray0_dir_y;
      r.ray1_dir_z = k * r.ray0_dir_z;
      r.ray1_origin_x = r.ray0_origin_x + a * r.ray0_dir_x + near_val(3000);
      r.ray1_origin_y = r.ray0_origin_y + a * r.ray0_dir_y + near_val(3000);
      r.ray1_origin_z = r.ray0_origin_z + a * r.ray0_dir_z;
    end
    return r;
  endfunction

  // one input beat, with a random gap in front while gaps are on
  task automatic send_pair(rri_pkg::rri_in_t r, bit typed, rri_pkg::rri_out_t want);
    if (gaps_on) begin
      while ($urandom_range(0, 99) < 34) begin
        push <= 1'b0;
        @(posedge clk);
      end
    end
    rays <= r;
    push <= 1'b1;
    do @(posedge clk); while (full);
    pending_q.push_back(typed ? want : closest_approach(r, threshold));
  endtask

  task automatic drain();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // apb write of the threshold register, block idle
  task automatic write_threshold(bit [30:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {rri_pkg::REG_THRESHOLD, 2'b00};
    pwdata  <= {1'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    threshold = value;
    @(posedge clk);
  endtask

  // result side: random stalls on pop while gaps are on
  always @(posedge clk) begin
    pop <= gaps_on ? ($urandom_range(0, 99) >= 34) : 1'b1;
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin
    rri_pkg::rri_out_t exp_r;
    if (!rst && pop && !empty) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result outcome %0d t0 %0d t1 %0d", $time,
                 result.outcome, result.param_first, result.param_second);
        errors++;
      end else begin
        exp_r = pending_q.pop_front();
        if (result.outcome !== exp_r.outcome) begin
          $display("%0t: outcome expected %0d actual %0d", $time,
                   exp_r.outcome, result.outcome);
          errors++;
        end
        if (result.param_first !== exp_r.param_first) begin
          $display("%0t: param_first expected %0d actual %0d", $time,
                   exp_r.param_first, result.param_first);
          errors++;
        end
        if (result.param_second !== exp_r.param_second) begin
          $display("%0t: param_second expected %0d actual %0d", $time,
                   exp_r.param_second, result.param_second);
          errors++;
        end
      end
    end
  end

  initial begin
    bit [30:0] settings[4];
    int        timer;
    rri_pkg::rri_out_t none;
    none      = '0;
    errors    = 0;
    gaps_on   = 1'b1;
    threshold = 31'd2048;
    rst     <= 1'b1;
    push    <= 1'b0;
    rays    <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed rows: outcome, t0, t1 typed where obvious
    directed.push_back('{'0, 1'b1, '{rri_pkg::OUTCOME_COINCIDENT, 32'sd0, 32'sd0}});
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                       32'sd0, 32'sd65536, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0},
                       1'b1, '{rri_pkg::OUTCOME_APART, 32'sd0, 32'sd0}});
    directed.push_back('{rri_pkg::rri_in_t'{12{rri_pkg::T_MIN}}, 1'b1,
                       '{rri_pkg::OUTCOME_COINCIDENT, 32'sd0, 32'sd0}});
    directed.push_back('{rri_pkg::rri_in_t'{12{rri_pkg::T_MAX}}, 1'b1,
                       '{rri_pkg::OUTCOME_COINCIDENT, 32'sd0, 32'sd0}});
    // perpendicular rays meeting at t0 = 2, t1 = -1
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                       32'sd0, 32'sd131072, 32'sd65536, 32'sd0, 32'sd0, 32'sd65536,
                       32'sd0},
                       1'b1, '{rri_pkg::OUTCOME_HIT, 32'sd131072, -32'sd65536}});
    // same rays one unit apart in z
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                       32'sd0, 32'sd131072, 32'sd65536, 32'sd65536, 32'sd0,
                       32'sd65536, 32'sd0},
                       1'b1, '{rri_pkg::OUTCOME_SKEW, 32'sd131072, -32'sd65536}});
    // extremes mixed, parameters saturate or not
    directed.push_back('{rri_pkg::rri_in_t'{rri_pkg::T_MIN, rri_pkg::T_MAX,
                       rri_pkg::T_MIN, rri_pkg::T_MAX, rri_pkg::T_MIN, rri_pkg::T_MAX,
                       rri_pkg::T_MAX, rri_pkg::T_MIN, rri_pkg::T_MAX, rri_pkg::T_MIN,
                       rri_pkg::T_MAX, rri_pkg::T_MAX}, 1'b0, none});
    directed.push_back('{rri_pkg::rri_in_t'{rri_pkg::T_MAX, rri_pkg::T_MAX,
                       rri_pkg::T_MAX, 32'sd1, 32'sd0, 32'sd0, rri_pkg::T_MIN,
                       rri_pkg::T_MIN, rri_pkg::T_MIN, 32'sd0, 32'sd1, 32'sd0},
                       1'b0, none});
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, rri_pkg::T_MIN,
                       32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0, rri_pkg::T_MIN,
                       32'sd0}, 1'b0, none});
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd1, 32'sd0,
                       32'sd0, rri_pkg::T_MAX, rri_pkg::T_MAX, 32'sd0, 32'sd0, 32'sd1,
                       32'sd0}, 1'b0, none});
    // parallel, origins exactly at the default threshold
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                       32'sd0, 32'sd0, 32'sd2048, 32'sd0, -32'sd65536, 32'sd0, 32'sd0},
                       1'b1, '{rri_pkg::OUTCOME_COINCIDENT, 32'sd0, 32'sd0}});
    directed.push_back('{rri_pkg::rri_in_t'{32'sd0, 32'sd0, 32'sd0, 32'sd65536, 32'sd0,
                       32'sd0, 32'sd0, 32'sd2049, 32'sd0, 32'sd65536, 32'sd0, 32'sd0},
                       1'b1, '{rri_pkg::OUTCOME_APART, 32'sd0, 32'sd0}});
    foreach (directed[i])
      send_pair(directed[i].rays, directed[i].typed, directed[i].want);
    for (int i = 0; i < 10; i++) send_pair(random_pair(), 1'b0, none);

    // random phases over several thresholds, extremes included
    settings[0] = 31'd0;
    settings[1] = 31'h7fff_ffff;
    settings[2] = 31'd65536;
    settings[3] = $urandom_range(0, 1 << 14);
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(settings[ph]);
      gaps_on = (ph != 2);
      for (int i = 0; i < 95; i++) begin
        send_pair(random_pair(), 1'b0, none);
        if (ph == 1 && i == 40) drain();
      end
    end
    gaps_on = 1'b1;

    push <= 1'b0;
    timer = 0;
    while (pending_q.size() != 0 && timer < 100000) begin
      @(posedge clk);
      timer++;
    end
    repeat (SETTLE) @(posedge clk);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("ray_ray_intersection_test test passed");
    end else begin
      $display("ray_ray_intersection_test test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/rri_pkg.sv
hdl/rri_fifo.sv
hdl/rri_front.sv
hdl/rri_back.sv
hdl/ray_ray_intersection_test.sv
tb/tb.sv
